>>> sv/lj_pkg.sv
package lj_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int IDX_W         = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int POS_W         = 32;
    localparam int ACC_W         = 48;
    localparam int CFG_W         = 32;
    localparam int PADDR_W       = 4;
    localparam int OUT_IDX_W     = 6;

    // register word indexes (byte address / 4)
    localparam logic [1:0] REG_CUTOFF = 2'd0;
    localparam logic [1:0] REG_SIGMA6 = 2'd1;
    localparam logic [1:0] REG_EPS    = 2'd2;

    typedef enum logic [4:0] {
        ST_LOAD, ST_CLR, ST_PRD, ST_DIFF, ST_MGO, ST_MWAIT, ST_CHK, ST_DGO, ST_DWAIT,
        ST_SIGN, ST_AIRD, ST_AIWR, ST_AJRD, ST_AJWR, ST_NEXT, ST_ORD, ST_OSET, ST_OWAIT
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_CLR, OP_PRD, OP_DIFF, OP_MUL_GO, OP_MUL_WAIT, OP_DIV_GO,
        OP_DIV_WAIT, OP_SIGN, OP_AI_RD, OP_AI_WR, OP_AJ_RD, OP_AJ_WR, OP_NEXT, OP_ORD,
        OP_OSET, OP_OWAIT
    } dp_op_t;

    typedef enum logic [3:0] {
        MS_SQX, MS_SQY, MS_SQZ, MS_I2, MS_I3, MS_S6, MS_S12, MS_FM, MS_G, MS_EM,
        MS_FX, MS_FY, MS_FZ
    } mstep_t;

    typedef enum logic [1:0] {SH_RAW, SH_24, SH_32} mul_sh_t;

    typedef struct packed {
        dp_op_t op;
        mstep_t mstep;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic skip;
        logic clr_last;
        logic n_lt2;
        logic pair_last;
        logic out_last;
        logic out_taken;
    } dp_status_t;

endpackage

>>> sv/lj_mul.sv
module lj_mul (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [63:0]      a,
    input  logic [63:0]      b,
    input  lj_pkg::mul_sh_t  sh,
    output logic             done,
    output logic [63:0]      res
);

    logic [63:0]     a_reg, b_reg, p_reg;
    lj_pkg::mul_sh_t sh_reg;
    logic [2:0]      cnt_reg;
    logic [1:0]      off_reg;
    logic            busy_reg, pv_reg, done_reg;
    logic [127:0]    prod_reg;
    logic [31:0]     a_part, b_part;
    logic [127:0]    shifted;

    assign a_part = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_part = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        case (off_reg)
            2'd0:    shifted = {64'd0, p_reg};
            2'd1:    shifted = {32'd0, p_reg, 32'd0};
            2'd2:    shifted = {p_reg, 64'd0};
            default: shifted = '0;
        endcase
    end

    // four 32x32 partial products, one per cycle, each summed in the following cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                b_reg    <= b;
                sh_reg   <= sh;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                pv_reg   <= 1'b0;
                prod_reg <= '0;
            end else if (busy_reg) begin
                if (cnt_reg != 3'd4) begin
                    p_reg   <= a_part * b_part;
                    off_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                    pv_reg  <= 1'b1;
                    cnt_reg <= cnt_reg + 3'd1;
                end else begin
                    pv_reg   <= 1'b0;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                if (pv_reg) begin
                    prod_reg <= prod_reg + shifted;
                end
            end
        end
    end

    always_comb begin
        unique case (sh_reg)
            lj_pkg::SH_32:  res = (|prod_reg[127:96]) ? '1 : prod_reg[95:32];
            lj_pkg::SH_24:  res = (|prod_reg[127:88]) ? '1 : prod_reg[87:24];
            lj_pkg::SH_RAW: res = prod_reg[63:0];
            default:        res = prod_reg[63:0];
        endcase
    end

    assign done = done_reg;

endmodule

>>> sv/lj_div.sv
module lj_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] divisor,
    output logic        done,
    output logic [63:0] quot
);

    localparam logic [6:0] LAST_STEP = 7'd64;

    logic [47:0] d_reg, rem_reg, rem_next;
    logic [64:0] q_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg, ge;
    logic [48:0] trial, diff;

    // dividend is 2^64: only its top bit is set
    assign trial    = {rem_reg, (cnt_reg == 7'd0)};
    assign ge       = trial >= {1'b0, d_reg};
    assign diff     = trial - {1'b0, d_reg};
    assign rem_next = ge ? diff[47:0] : trial[47:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                d_reg    <= divisor;
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                q_reg   <= {q_reg[63:0], ge};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg[64] ? '1 : q_reg[63:0];

endmodule

>>> sv/lj_dp.sv
module lj_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lj_pkg::dp_cmd_t                   cmd,
    output lj_pkg::dp_status_t                status,
    input  logic [lj_pkg::POS_W-1:0]          s_pos_x,
    input  logic [lj_pkg::POS_W-1:0]          s_pos_y,
    input  logic [lj_pkg::POS_W-1:0]          s_pos_z,
    input  logic                              s_final_particle,
    input  logic [lj_pkg::CFG_W-1:0]          cutoff_squared,
    input  logic [lj_pkg::CFG_W-1:0]          sigma_pow6,
    input  logic [lj_pkg::CFG_W-1:0]          well_depth,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [lj_pkg::OUT_IDX_W-1:0]      m_particle_index,
    output logic signed [lj_pkg::ACC_W-1:0]   m_force_x,
    output logic signed [lj_pkg::ACC_W-1:0]   m_force_y,
    output logic signed [lj_pkg::ACC_W-1:0]   m_force_z,
    output logic signed [lj_pkg::ACC_W-1:0]   m_total_energy,
    output logic                              m_final_result
);

    localparam int MAXP = lj_pkg::MAX_PARTICLES;
    localparam int IW   = lj_pkg::IDX_W;
    localparam int CW   = lj_pkg::CNT_W;
    localparam int AW   = lj_pkg::ACC_W;

    function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] x, input logic [AW-1:0] y);
        logic [AW:0] s;
        s = {x[AW-1], x} + {y[AW-1], y};
        if (s[AW] != s[AW-1]) begin
            return s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] clamp_signed(input logic [63:0] mag, input logic neg);
        logic [AW-2:0] v;
        v = (|mag[63:AW-1]) ? '1 : mag[AW-2:0];
        return neg ? ({AW{1'b0}} - {1'b0, v}) : {1'b0, v};
    endfunction

    function automatic logic [63:0] sat_mul24(input logic [63:0] x);
        logic [68:0] p;
        p = {1'b0, x, 4'd0} + {2'd0, x, 3'd0};
        return (|p[68:64]) ? '1 : p[63:0];
    endfunction

    // ---------------- counters and control registers
    logic [CW-1:0] count_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic          m_valid_reg;
    logic          clr_last, n_lt2, pair_last, out_last, out_taken, store_we;

    assign clr_last  = CW'(k_reg) == count_reg - CW'(1);
    assign out_last  = clr_last;
    assign n_lt2     = count_reg < CW'(2);
    assign pair_last = (CW'(j_reg) == count_reg - CW'(1)) && (CW'(i_reg) == count_reg - CW'(2));
    assign out_taken = m_valid_reg && m_ready;
    assign store_we  = (cmd.op == lj_pkg::OP_LOAD) && (count_reg < CW'(MAXP));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                lj_pkg::OP_LOAD: begin
                    if (store_we) begin
                        count_reg <= count_reg + CW'(1);
                    end
                    if (s_final_particle) begin
                        i_reg <= '0;
                        j_reg <= IW'(1);
                        k_reg <= '0;
                    end
                end
                lj_pkg::OP_CLR: begin
                    k_reg <= clr_last ? '0 : k_reg + IW'(1);
                end
                lj_pkg::OP_NEXT: begin
                    if (CW'(j_reg) == count_reg - CW'(1)) begin
                        i_reg <= i_reg + IW'(1);
                        j_reg <= i_reg + IW'(2);
                    end else begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                lj_pkg::OP_OSET: begin
                    m_valid_reg <= 1'b1;
                end
                lj_pkg::OP_OWAIT: begin
                    if (out_taken) begin
                        m_valid_reg <= 1'b0;
                        if (out_last) begin
                            k_reg     <= '0;
                            count_reg <= '0;
                        end else begin
                            k_reg <= k_reg + IW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- position store, two read ports
    logic [31:0] store_x_mem [MAXP];
    logic [31:0] store_y_mem [MAXP];
    logic [31:0] store_z_mem [MAXP];
    logic [31:0] pi_rd [3];
    logic [31:0] pj_rd [3];

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_x_mem[count_reg[IW-1:0]] <= s_pos_x;
            store_y_mem[count_reg[IW-1:0]] <= s_pos_y;
            store_z_mem[count_reg[IW-1:0]] <= s_pos_z;
        end
        if (cmd.op == lj_pkg::OP_PRD) begin
            pi_rd[0] <= store_x_mem[i_reg];
            pi_rd[1] <= store_y_mem[i_reg];
            pi_rd[2] <= store_z_mem[i_reg];
            pj_rd[0] <= store_x_mem[j_reg];
            pj_rd[1] <= store_y_mem[j_reg];
            pj_rd[2] <= store_z_mem[j_reg];
        end
    end

    // ---------------- displacement
    logic [32:0] d_w [3];
    logic [32:0] dmag_w [3];
    logic [23:0] ad_reg [3];
    logic [2:0]  dneg_reg;
    logic        far_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            d_w[a]    = {pj_rd[a][31], pj_rd[a]} - {pi_rd[a][31], pi_rd[a]};
            dmag_w[a] = d_w[a][32] ? (33'd0 - d_w[a]) : d_w[a];
        end
    end

    // ---------------- arithmetic registers
    logic [49:0] r_reg;
    logic [63:0] inv_reg, t_reg, s6_reg, s12_reg, fmag_reg, emag_reg, g_reg;
    logic        fneg_reg, eneg_reg;
    logic [AW-1:0] f_reg [3];
    logic [AW-1:0] energy_reg;

    logic [63:0]     mul_a, mul_b, mres, quot, eps64, a2, e64;
    lj_pkg::mul_sh_t mul_sh;
    logic            mul_done, div_done, fneg_w, eneg_w, skip;

    assign eps64 = {16'd0, well_depth, 16'd0};
    assign a2    = s12_reg[63] ? '1 : {s12_reg[62:0], 1'b0};
    assign fneg_w = a2 < s6_reg;
    assign eneg_w = s12_reg < s6_reg;
    assign e64    = (|mres[63:62]) ? {8'd0, {56{1'b1}}} : {8'd0, mres[61:6]};
    assign skip   = far_reg || (r_reg == '0) || (r_reg >= {2'd0, cutoff_squared, 16'd0});

    always_comb begin
        mul_a  = inv_reg;
        mul_b  = inv_reg;
        mul_sh = lj_pkg::SH_32;
        unique case (cmd.mstep)
            lj_pkg::MS_SQX: begin
                mul_a = {40'd0, ad_reg[0]}; mul_b = {40'd0, ad_reg[0]}; mul_sh = lj_pkg::SH_RAW;
            end
            lj_pkg::MS_SQY: begin
                mul_a = {40'd0, ad_reg[1]}; mul_b = {40'd0, ad_reg[1]}; mul_sh = lj_pkg::SH_RAW;
            end
            lj_pkg::MS_SQZ: begin
                mul_a = {40'd0, ad_reg[2]}; mul_b = {40'd0, ad_reg[2]}; mul_sh = lj_pkg::SH_RAW;
            end
            lj_pkg::MS_I2:  begin mul_a = inv_reg; mul_b = inv_reg; end
            lj_pkg::MS_I3:  begin mul_a = t_reg; mul_b = inv_reg; end
            lj_pkg::MS_S6:  begin mul_a = {16'd0, sigma_pow6, 16'd0}; mul_b = t_reg; end
            lj_pkg::MS_S12: begin mul_a = s6_reg; mul_b = s6_reg; end
            lj_pkg::MS_FM:  begin mul_a = fmag_reg; mul_b = eps64; end
            lj_pkg::MS_G:   begin mul_a = sat_mul24(t_reg); mul_b = inv_reg; end
            lj_pkg::MS_EM:  begin mul_a = emag_reg; mul_b = eps64; end
            lj_pkg::MS_FX: begin
                mul_a = g_reg; mul_b = {40'd0, ad_reg[0]}; mul_sh = lj_pkg::SH_24;
            end
            lj_pkg::MS_FY: begin
                mul_a = g_reg; mul_b = {40'd0, ad_reg[1]}; mul_sh = lj_pkg::SH_24;
            end
            lj_pkg::MS_FZ: begin
                mul_a = g_reg; mul_b = {40'd0, ad_reg[2]}; mul_sh = lj_pkg::SH_24;
            end
            default: ;
        endcase
    end

    lj_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == lj_pkg::OP_MUL_GO),
        .a       (mul_a),
        .b       (mul_b),
        .sh      (mul_sh),
        .done    (mul_done),
        .res     (mres)
    );

    lj_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == lj_pkg::OP_DIV_GO),
        .divisor (r_reg[47:0]),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        case (cmd.op)
            lj_pkg::OP_LOAD: begin
                if (s_final_particle) begin
                    energy_reg <= '0;
                end
            end
            lj_pkg::OP_DIFF: begin
                for (int a = 0; a < 3; a++) begin
                    ad_reg[a]   <= dmag_w[a][23:0];
                    dneg_reg[a] <= d_w[a][32];
                end
                far_reg <= (|dmag_w[0][32:24]) || (|dmag_w[1][32:24]) || (|dmag_w[2][32:24]);
            end
            lj_pkg::OP_DIV_WAIT: begin
                if (div_done) begin
                    inv_reg <= quot;
                end
            end
            lj_pkg::OP_SIGN: begin
                fneg_reg <= fneg_w;
                fmag_reg <= fneg_w ? s6_reg - a2 : a2 - s6_reg;
                eneg_reg <= eneg_w;
                emag_reg <= eneg_w ? s6_reg - s12_reg : s12_reg - s6_reg;
            end
            lj_pkg::OP_MUL_WAIT: begin
                if (mul_done) begin
                    unique case (cmd.mstep)
                        lj_pkg::MS_SQX: r_reg <= mres[49:0];
                        lj_pkg::MS_SQY, lj_pkg::MS_SQZ: r_reg <= r_reg + mres[49:0];
                        lj_pkg::MS_I2, lj_pkg::MS_I3, lj_pkg::MS_FM: t_reg <= mres;
                        lj_pkg::MS_S6:  s6_reg  <= mres;
                        lj_pkg::MS_S12: s12_reg <= mres;
                        lj_pkg::MS_G:   g_reg   <= mres;
                        lj_pkg::MS_EM: begin
                            // scale by four, drop eight fraction bits, clamp and sum
                            energy_reg <= sat_add(energy_reg, clamp_signed(e64, eneg_reg));
                        end
                        lj_pkg::MS_FX: f_reg[0] <= clamp_signed(mres, fneg_reg ^ dneg_reg[0]);
                        lj_pkg::MS_FY: f_reg[1] <= clamp_signed(mres, fneg_reg ^ dneg_reg[1]);
                        lj_pkg::MS_FZ: f_reg[2] <= clamp_signed(mres, fneg_reg ^ dneg_reg[2]);
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // ---------------- force accumulators, one write and one read port
    logic [AW-1:0] acc_x_mem [MAXP];
    logic [AW-1:0] acc_y_mem [MAXP];
    logic [AW-1:0] acc_z_mem [MAXP];
    logic [AW-1:0] acc_rd [3];
    logic [AW-1:0] acc_wd [3];
    logic [IW-1:0] acc_ra, acc_wa;
    logic          acc_we;

    always_comb begin
        acc_we = 1'b0;
        acc_wa = k_reg;
        acc_ra = k_reg;
        for (int a = 0; a < 3; a++) begin
            acc_wd[a] = '0;
        end
        case (cmd.op)
            lj_pkg::OP_CLR: acc_we = 1'b1;
            lj_pkg::OP_AI_RD: acc_ra = i_reg;
            lj_pkg::OP_AJ_RD: acc_ra = j_reg;
            lj_pkg::OP_AI_WR: begin
                acc_we = 1'b1;
                acc_wa = i_reg;
                for (int a = 0; a < 3; a++) begin
                    acc_wd[a] = sat_add(acc_rd[a], f_reg[a]);
                end
            end
            lj_pkg::OP_AJ_WR: begin
                acc_we = 1'b1;
                acc_wa = j_reg;
                for (int a = 0; a < 3; a++) begin
                    acc_wd[a] = sat_add(acc_rd[a], {AW{1'b0}} - f_reg[a]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_x_mem[acc_wa] <= acc_wd[0];
            acc_y_mem[acc_wa] <= acc_wd[1];
            acc_z_mem[acc_wa] <= acc_wd[2];
        end
        acc_rd[0] <= acc_x_mem[acc_ra];
        acc_rd[1] <= acc_y_mem[acc_ra];
        acc_rd[2] <= acc_z_mem[acc_ra];
    end

    // ---------------- output word register
    logic [lj_pkg::OUT_IDX_W-1:0] idx_out_reg;
    logic [AW-1:0] fx_out_reg, fy_out_reg, fz_out_reg, e_out_reg;
    logic          last_out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.op == lj_pkg::OP_OSET) begin
            idx_out_reg  <= lj_pkg::OUT_IDX_W'(k_reg);
            fx_out_reg   <= acc_rd[0];
            fy_out_reg   <= acc_rd[1];
            fz_out_reg   <= acc_rd[2];
            e_out_reg    <= energy_reg;
            last_out_reg <= out_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_particle_index = idx_out_reg;
    assign m_force_x        = fx_out_reg;
    assign m_force_y        = fy_out_reg;
    assign m_force_z        = fz_out_reg;
    assign m_total_energy   = e_out_reg;
    assign m_final_result   = last_out_reg;

    always_comb begin
        status.mul_done  = mul_done;
        status.div_done  = div_done;
        status.skip      = skip;
        status.clr_last  = clr_last;
        status.n_lt2     = n_lt2;
        status.pair_last = pair_last;
        status.out_last  = out_last;
        status.out_taken = out_taken;
    end

endmodule

>>> sv/lj_ctrl.sv
module lj_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_final_particle,
    input  lj_pkg::dp_status_t status,
    output logic               s_ready,
    output lj_pkg::dp_cmd_t    cmd
);

    lj_pkg::state_t state_reg, state_next;
    lj_pkg::mstep_t mstep_reg, mstep_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lj_pkg::ST_LOAD;
            mstep_reg <= lj_pkg::MS_SQX;
        end else begin
            state_reg <= state_next;
            mstep_reg <= mstep_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mstep_next = mstep_reg;
        unique case (state_reg)
            lj_pkg::ST_LOAD: if (s_valid && s_final_particle) state_next = lj_pkg::ST_CLR;
            lj_pkg::ST_CLR: begin
                if (status.clr_last) begin
                    state_next = status.n_lt2 ? lj_pkg::ST_ORD : lj_pkg::ST_PRD;
                end
            end
            lj_pkg::ST_PRD: state_next = lj_pkg::ST_DIFF;
            lj_pkg::ST_DIFF: begin
                state_next = lj_pkg::ST_MGO;
                mstep_next = lj_pkg::MS_SQX;
            end
            lj_pkg::ST_MGO: state_next = lj_pkg::ST_MWAIT;
            lj_pkg::ST_MWAIT: begin
                if (status.mul_done) begin
                    unique case (mstep_reg)
                        lj_pkg::MS_SQZ: state_next = lj_pkg::ST_CHK;
                        lj_pkg::MS_S12: state_next = lj_pkg::ST_SIGN;
                        lj_pkg::MS_FZ:  state_next = lj_pkg::ST_AIRD;
                        default: begin
                            state_next = lj_pkg::ST_MGO;
                            mstep_next = lj_pkg::mstep_t'(mstep_reg + 4'd1);
                        end
                    endcase
                end
            end
            lj_pkg::ST_CHK: state_next = status.skip ? lj_pkg::ST_NEXT : lj_pkg::ST_DGO;
            lj_pkg::ST_DGO: state_next = lj_pkg::ST_DWAIT;
            lj_pkg::ST_DWAIT: begin
                if (status.div_done) begin
                    state_next = lj_pkg::ST_MGO;
                    mstep_next = lj_pkg::MS_I2;
                end
            end
            lj_pkg::ST_SIGN: begin
                state_next = lj_pkg::ST_MGO;
                mstep_next = lj_pkg::MS_FM;
            end
            lj_pkg::ST_AIRD: state_next = lj_pkg::ST_AIWR;
            lj_pkg::ST_AIWR: state_next = lj_pkg::ST_AJRD;
            lj_pkg::ST_AJRD: state_next = lj_pkg::ST_AJWR;
            lj_pkg::ST_AJWR: state_next = lj_pkg::ST_NEXT;
            lj_pkg::ST_NEXT: state_next = status.pair_last ? lj_pkg::ST_ORD : lj_pkg::ST_PRD;
            lj_pkg::ST_ORD:  state_next = lj_pkg::ST_OSET;
            lj_pkg::ST_OSET: state_next = lj_pkg::ST_OWAIT;
            lj_pkg::ST_OWAIT: begin
                if (status.out_taken) begin
                    state_next = status.out_last ? lj_pkg::ST_LOAD : lj_pkg::ST_ORD;
                end
            end
            default: state_next = lj_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        cmd.mstep = mstep_reg;
        cmd.op    = lj_pkg::OP_IDLE;
        unique case (state_reg)
            lj_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                cmd.op  = s_valid ? lj_pkg::OP_LOAD : lj_pkg::OP_IDLE;
            end
            lj_pkg::ST_CLR:   cmd.op = lj_pkg::OP_CLR;
            lj_pkg::ST_PRD:   cmd.op = lj_pkg::OP_PRD;
            lj_pkg::ST_DIFF:  cmd.op = lj_pkg::OP_DIFF;
            lj_pkg::ST_MGO:   cmd.op = lj_pkg::OP_MUL_GO;
            lj_pkg::ST_MWAIT: cmd.op = lj_pkg::OP_MUL_WAIT;
            lj_pkg::ST_CHK:   cmd.op = lj_pkg::OP_IDLE;
            lj_pkg::ST_DGO:   cmd.op = lj_pkg::OP_DIV_GO;
            lj_pkg::ST_DWAIT: cmd.op = lj_pkg::OP_DIV_WAIT;
            lj_pkg::ST_SIGN:  cmd.op = lj_pkg::OP_SIGN;
            lj_pkg::ST_AIRD:  cmd.op = lj_pkg::OP_AI_RD;
            lj_pkg::ST_AIWR:  cmd.op = lj_pkg::OP_AI_WR;
            lj_pkg::ST_AJRD:  cmd.op = lj_pkg::OP_AJ_RD;
            lj_pkg::ST_AJWR:  cmd.op = lj_pkg::OP_AJ_WR;
            lj_pkg::ST_NEXT:  cmd.op = lj_pkg::OP_NEXT;
            lj_pkg::ST_ORD:   cmd.op = lj_pkg::OP_ORD;
            lj_pkg::ST_OSET:  cmd.op = lj_pkg::OP_OSET;
            lj_pkg::ST_OWAIT: cmd.op = lj_pkg::OP_OWAIT;
            default:          cmd.op = lj_pkg::OP_IDLE;
        endcase
    end

endmodule

>>> sv/lennard_jones_force_engine.sv
// Lennard-Jones pair force engine with cutoff.
// Input channel (s_*): one position word per particle, signed Q16.16 x/y/z. The word
// with s_final_particle set closes the set and starts the force pass; words beyond
// 64 particles are dropped, but their final flag still starts the pass.
// Output channel (m_*): one word per loaded particle in load order, carrying the
// Q24.24 force, the total pair energy (same on every word) and a last flag.
// APB port: cutoff_squared at 0x0, sigma_pow6 at 0x4, well_depth at 0x8; write only
// while idle. pready is tied high.
// Timing: loading accepts one word per cycle. The pass clears n accumulators, then
// walks all n*(n-1)/2 pairs on one shared pair unit: a pair outside the cutoff
// needs only the squared distance, one inside it also the 65-step reciprocal
// divider and further 64x64 products, each formed as four 32x32 partial products.
// Results then leave one word at a time, each read from the accumulators and
// registered before it is offered. A stalled receiver holds the current result
// word; nothing advances until it is taken. No new position is accepted until the
// last result word of a pass leaves. Reset (synchronous, aresetn low) returns to
// loading with an empty set and the register defaults 6.25, 1.0 and 1.0.
module lennard_jones_force_engine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lj_pkg::PADDR_W-1:0]         paddr,
    input  logic [lj_pkg::CFG_W-1:0]           pwdata,
    output logic [lj_pkg::CFG_W-1:0]           prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [lj_pkg::POS_W-1:0]    s_pos_x,
    input  logic signed [lj_pkg::POS_W-1:0]    s_pos_y,
    input  logic signed [lj_pkg::POS_W-1:0]    s_pos_z,
    input  logic                               s_final_particle,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lj_pkg::OUT_IDX_W-1:0]       m_particle_index,
    output logic signed [lj_pkg::ACC_W-1:0]    m_force_x,
    output logic signed [lj_pkg::ACC_W-1:0]    m_force_y,
    output logic signed [lj_pkg::ACC_W-1:0]    m_force_z,
    output logic signed [lj_pkg::ACC_W-1:0]    m_total_energy,
    output logic                               m_final_result
);

    logic [lj_pkg::CFG_W-1:0] cutoff_reg, sigma6_reg, eps_reg;
    logic                     cfg_wr;
    lj_pkg::dp_cmd_t          cmd;
    lj_pkg::dp_status_t       status;

    // APB register file: write on the access phase, read is combinational
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= 32'd409600;
            sigma6_reg <= 32'd65536;
            eps_reg    <= 32'd65536;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                lj_pkg::REG_CUTOFF: cutoff_reg <= pwdata;
                lj_pkg::REG_SIGMA6: sigma6_reg <= pwdata;
                lj_pkg::REG_EPS:    eps_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            lj_pkg::REG_CUTOFF: prdata = cutoff_reg;
            lj_pkg::REG_SIGMA6: prdata = sigma6_reg;
            lj_pkg::REG_EPS:    prdata = eps_reg;
            default:            prdata = '0;
        endcase
    end

    // sequencer: load, clear, pair walk, drain
    lj_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_final_particle (s_final_particle),
        .status           (status),
        .s_ready          (s_ready),
        .cmd              (cmd)
    );

    // stores, pair arithmetic, accumulators and output word register
    lj_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_final_particle (s_final_particle),
        .cutoff_squared   (cutoff_reg),
        .sigma_pow6       (sigma6_reg),
        .well_depth       (eps_reg),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_particle_index (m_particle_index),
        .m_force_x        (m_force_x),
        .m_force_y        (m_force_y),
        .m_force_z        (m_force_z),
        .m_total_energy   (m_total_energy),
        .m_final_result   (m_final_result)
    );

    // loading and draining never overlap
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input accepted while a result word is pending");

    // a final word closes the set: loading stops at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_particle) |=> !s_ready)
        else $error("loading continued after the final particle");

    // a non-final result is followed by another result, not by loading
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_final_result) |=> (!m_valid && !s_ready))
        else $error("drain ended before the last result word");

endmodule

>>> sim/lennard_jones_force_engine_tb.sv
module lennard_jones_force_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // clock, reset and the ports of the block
    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite, pready;
    logic [lj_pkg::PADDR_W-1:0] paddr;
    logic [lj_pkg::CFG_W-1:0] pwdata, prdata;
    logic s_valid, s_ready, s_final_particle;
    logic signed [lj_pkg::POS_W-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic m_valid, m_ready, m_final_result;
    logic [lj_pkg::OUT_IDX_W-1:0] m_particle_index;
    logic signed [lj_pkg::ACC_W-1:0] m_force_x, m_force_y, m_force_z, m_total_energy;

    lennard_jones_force_engine DUT (.*);

    // one force word as the block should emit it
    typedef struct {
        logic [lj_pkg::OUT_IDX_W-1:0] idx;
        logic [lj_pkg::ACC_W-1:0] fx, fy, fz, energy;
        logic last;
    } force_word_t;

    // one row of the directed table: a position word, and whether the
    // whole set it closes is known to produce zero force and zero energy
    typedef struct {
        logic [31:0] x, y, z;
        bit fin;
        bit all_zero;
    } dir_row_t;

    force_word_t pending_forces[$];

    // shadow copy of the block's registers and stores
    logic [31:0] cut_sq, sig6, eps_q;
    longint part_x[lj_pkg::MAX_PARTICLES], part_y[lj_pkg::MAX_PARTICLES];
    longint part_z[lj_pkg::MAX_PARTICLES];
    longint sum_fx[lj_pkg::MAX_PARTICLES], sum_fy[lj_pkg::MAX_PARTICLES];
    longint sum_fz[lj_pkg::MAX_PARTICLES];
    longint pass_energy;
    int n_loaded;

    int errors;
    int words_sent;
    bit no_idle;  // set during the long stretch with no idling on either side

    localparam longint POS_LIM = 64'h7FFF_FFFF_FFFF;

    // ---------------------------------------------------------------
    // Fixed-point helpers for the force predictor
    // ---------------------------------------------------------------

    // floor(a*b / 2^sh), saturated to 64 bits
    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if ((p >> (64 + sh)) != 0) return '1;
        return 64'(p >> sh);
    endfunction

    function automatic logic [63:0] mul_const(logic [63:0] a, logic [63:0] k);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, k};
        if (p[127:64] != 0) return '1;
        return p[63:0];
    endfunction

    // clamp into the 48-bit signed range
    function automatic longint clamp_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > POS_LIM) return POS_LIM;
        if (s < -POS_LIM - 1) return -POS_LIM - 1;
        return s;
    endfunction

    function automatic longint mag_to_signed(logic [63:0] mag, bit neg);
        longint v;
        v = (mag > 64'(POS_LIM)) ? POS_LIM : longint'(mag);
        return neg ? -v : v;
    endfunction

    // add the force of pair (i, j) into the sums, i < j
    function automatic void add_pair_force(int i, int j);
        longint d[3];
        logic [63:0] ad[3];
        logic [63:0] r2, inv, i3, s6, s12, twice, mag, g, emag, eps64;
        logic [127:0] q;
        longint f;
        bit fneg, eneg;
        d[0] = part_x[j] - part_x[i];
        d[1] = part_y[j] - part_y[i];
        d[2] = part_z[j] - part_z[i];
        r2 = 0;
        for (int k = 0; k < 3; k++) begin
            ad[k] = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
            // a component of 256.0 or more puts the pair beyond any cutoff
            if (ad[k] >= 64'd1 << 24) return;
            r2 += ad[k] * ad[k];
        end
        if (r2 == 0 || r2 >= ({32'd0, cut_sq} << 16)) return;
        q = (128'd1 << 64) / {64'd0, r2};
        inv = (q[127:64] != 0) ? '1 : q[63:0];
        i3 = mul_shift(mul_shift(inv, inv, 32), inv, 32);
        s6 = mul_shift({32'd0, sig6} << 16, i3, 32);
        s12 = mul_shift(s6, s6, 32);
        eps64 = {32'd0, eps_q} << 16;

        twice = (s12 > ~s12) ? '1 : s12 + s12;
        fneg = twice < s6;
        mag = fneg ? s6 - twice : twice - s6;
        g = mul_shift(mul_const(mul_shift(mag, eps64, 32), 24), inv, 32);

        eneg = s12 < s6;
        emag = eneg ? s6 - s12 : s12 - s6;
        emag = mul_const(mul_shift(emag, eps64, 32), 4) >> 8;
        pass_energy = clamp_add(pass_energy, mag_to_signed(emag, eneg));

        for (int k = 0; k < 3; k++) begin
            f = mag_to_signed(mul_shift(g, ad[k], 24), fneg != (d[k] < 0));
            case (k)
                0: begin
                    sum_fx[i] = clamp_add(sum_fx[i], f);
                    sum_fx[j] = clamp_add(sum_fx[j], -f);
                end
                1: begin
                    sum_fy[i] = clamp_add(sum_fy[i], f);
                    sum_fy[j] = clamp_add(sum_fy[j], -f);
                end
                default: begin
                    sum_fz[i] = clamp_add(sum_fz[i], f);
                    sum_fz[j] = clamp_add(sum_fz[j], -f);
                end
            endcase
        end
    endfunction

    // Take one accepted position word. On the final word run the whole pass
    // and queue one force word per stored particle. With all_zero set the
    // expected words are the plain zero set rather than the computed one.
    function automatic void load_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          bit fin, bit all_zero);
        force_word_t w;
        if (n_loaded < lj_pkg::MAX_PARTICLES) begin
            part_x[n_loaded] = longint'(signed'(x));
            part_y[n_loaded] = longint'(signed'(y));
            part_z[n_loaded] = longint'(signed'(z));
            n_loaded++;
        end
        if (!fin) return;
        for (int i = 0; i < n_loaded; i++) begin
            sum_fx[i] = 0;
            sum_fy[i] = 0;
            sum_fz[i] = 0;
        end
        pass_energy = 0;
        for (int i = 0; i < n_loaded; i++)
            for (int j = i + 1; j < n_loaded; j++)
                add_pair_force(i, j);
        for (int i = 0; i < n_loaded; i++) begin
            w.idx = lj_pkg::OUT_IDX_W'(i);
            w.fx = all_zero ? '0 : lj_pkg::ACC_W'(sum_fx[i]);
            w.fy = all_zero ? '0 : lj_pkg::ACC_W'(sum_fy[i]);
            w.fz = all_zero ? '0 : lj_pkg::ACC_W'(sum_fz[i]);
            w.energy = all_zero ? '0 : lj_pkg::ACC_W'(pass_energy);
            w.last = (i + 1 == n_loaded);
            pending_forces.push_back(w);
        end
        n_loaded = 0;
    endfunction

    // ---------------------------------------------------------------
    // Clock and run limit
    // ---------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Result side: random stalls, compare each taken word with the oldest
    // expectation
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        force_word_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 15);
            if (m_valid && m_ready) begin
                if (pending_forces.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected force word idx=%0d at %0t",
                                 m_particle_index, $realtime);
                end else begin
                    e = pending_forces.pop_front();
                    if (m_particle_index !== e.idx || m_force_x !== e.fx ||
                        m_force_y !== e.fy || m_force_z !== e.fz ||
                        m_total_energy !== e.energy || m_final_result !== e.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  exp idx=%0d fx=%h fy=%h fz=%h e=%h last=%b",
                                     e.idx, e.fx, e.fy, e.fz, e.energy, e.last);
                            $display("  got idx=%0d fx=%h fy=%h fz=%h e=%h last=%b",
                                     m_particle_index, m_force_x, m_force_y, m_force_z,
                                     m_total_energy, m_final_result);
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus tasks
    // ---------------------------------------------------------------

    // Send one position word: random idle gap first, then hold valid until
    // the handshake. Valid stays high into the next word when no gap follows.
    task automatic send_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 bit fin, bit all_zero);
        int gap;
        gap = 0;
        while (!no_idle && $urandom_range(99) < 15) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= x;
        s_pos_y <= y;
        s_pos_z <= z;
        s_final_particle <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        load_particle(x, y, z, fin, all_zero);
        words_sent++;
    endtask

    // Wait for the block to drain, then write one register and read it back.
    task automatic write_register(logic [1:0] ridx, logic [31:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_forces.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        // setup then access
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {ridx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (ridx)
            lj_pkg::REG_CUTOFF: cut_sq = value;
            lj_pkg::REG_SIGMA6: sig6 = value;
            default:            eps_q = value;
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== value) begin
            errors++;
            if (errors <= 10)
                $display("register %0d reads %h, wrote %h", ridx, prdata, value);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_register_value(logic [31:0] dflt);
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return dflt;
            3: return $urandom;
            default: return $urandom_range(32'h0010_0000, 32'h0000_4000);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    dir_row_t dir_rows[16];

    initial begin
        int set_no, n, base_x, base_y, base_z;
        logic [31:0] cv;

        // directed table: single particle, extreme far pair, coincident pair,
        // unit distance, smallest nonzero distance (reciprocal saturates),
        // exactly at the cutoff, just inside it, and a small mixed-sign trio
        dir_rows = '{
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1},
            '{32'h0005_0000, 32'hFFFB_0000, 32'h0005_0000, 1'b0, 1'b0},
            '{32'h0005_0000, 32'hFFFB_0000, 32'h0005_0000, 1'b1, 1'b1},
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
            '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
            '{32'h0002_8000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 32'h0002_7FFF, 32'h0000_0000, 1'b1, 1'b0},
            '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0, 1'b0},
            '{32'h0000_8000, 32'hFFFF_8000, 32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 32'h0000_0000, 32'h0001_8000, 1'b1, 1'b0}
        };

        // hold every input at a known value with reset asserted
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_pos_z = '0;
        s_final_particle = 1'b0;
        no_idle = 1'b0;
        errors = 0;
        words_sent = 0;
        n_loaded = 0;
        cut_sq = 32'd409600;
        sig6 = 32'd65536;
        eps_q = 32'd65536;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r])
            send_particle(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                          dir_rows[r].fin, dir_rows[r].all_zero);

        // drive every register to an extreme, then back to something usable
        write_register(lj_pkg::REG_CUTOFF, 32'hFFFF_FFFF);
        write_register(lj_pkg::REG_SIGMA6, 32'hFFFF_FFFF);
        write_register(lj_pkg::REG_EPS, 32'hFFFF_FFFF);
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        send_particle(32'h0000_4000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        write_register(lj_pkg::REG_CUTOFF, 32'd0);
        write_register(lj_pkg::REG_SIGMA6, 32'd0);
        write_register(lj_pkg::REG_EPS, 32'd0);
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        send_particle(32'h0000_4000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
        write_register(lj_pkg::REG_CUTOFF, 32'd409600);
        write_register(lj_pkg::REG_SIGMA6, 32'd65536);
        write_register(lj_pkg::REG_EPS, 32'd65536);

        // random sets; mostly tight clusters so pairs land inside the cutoff
        set_no = 0;
        while (words_sent < 380) begin
            no_idle = (words_sent >= 150 && words_sent < 250);
            if (set_no % 20 == 19) begin
                cv = pick_register_value(32'd409600);
                write_register(lj_pkg::REG_CUTOFF, cv);
                write_register(lj_pkg::REG_SIGMA6, pick_register_value(32'd65536));
                write_register(lj_pkg::REG_EPS, pick_register_value(32'd65536));
            end
            if (set_no == 30) begin
                // overflow the store: 66 spread-out words, the last two dropped
                for (int k = 0; k < lj_pkg::MAX_PARTICLES + 2; k++)
                    send_particle($urandom, $urandom, $urandom,
                                  k == lj_pkg::MAX_PARTICLES + 1, 1'b0);
            end else if ($urandom_range(9) == 0) begin
                // noise: full-range positions
                n = $urandom_range(4, 1);
                for (int k = 0; k < n; k++)
                    send_particle($urandom, $urandom, $urandom, k == n - 1, 1'b0);
            end else begin
                n = $urandom_range(6, 2);
                base_x = $urandom;
                base_y = $urandom;
                base_z = $urandom;
                for (int k = 0; k < n; k++)
                    send_particle(base_x + $urandom_range(32'h0002_0000) - 32'h0001_0000,
                                  base_y + $urandom_range(32'h0002_0000) - 32'h0001_0000,
                                  base_z + $urandom_range(32'h0002_0000) - 32'h0001_0000,
                                  k == n - 1, 1'b0);
            end
            set_no++;
        end
        no_idle = 1'b0;

        // drain: drop valid, wait for every expected word, then settle
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_forces.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
